>>> sv/sle_pkg.sv
// ============================================================================
// sle_pkg: shared definitions for the sequential list engine
// Field widths, action and status codes, cell command word and FSM states.
// ============================================================================
package sle_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 3;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_GET    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOCATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    // command broadcast to every cell during the execute cycle
    typedef struct packed {
        logic insert;     // open a slot at idx, load key there
        logic remove;     // close the slot at idx
        logic probe_pos;  // flag the cell at idx
        logic probe_val;  // flag every live cell whose entry equals key
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } state_t;

endpackage

>>> sv/sle_cell.sv
// ============================================================================
// sle_cell: one list slot
// Holds one entry, shifts to or from its neighbors, and flags a match.
// ============================================================================
module sle_cell #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  sle_pkg::cell_cmd_t          cmd,
    input  logic [IDX_W-1:0]            idx,
    input  logic [CNT_W-1:0]            count,
    input  logic [sle_pkg::VALUE_W-1:0] key,
    input  logic [sle_pkg::VALUE_W-1:0] left_data,
    input  logic [sle_pkg::VALUE_W-1:0] right_data,
    output logic [sle_pkg::VALUE_W-1:0] data,
    output logic                        hit
);
    import sle_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               hit_reg;
    logic               hit_next;
    logic               at_idx;
    logic               past_idx;
    logic               live;

    assign at_idx   = (MY_IDX == idx);
    assign past_idx = (MY_IDX > idx);
    assign live     = (MY_CNT < count);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert && at_idx)
        begin
            data_next = key;
        end
        else if (cmd.insert && past_idx)
        begin
            data_next = left_data;
        end
        else if (cmd.remove && (at_idx || past_idx))
        begin
            data_next = right_data;
        end
        // hold the flag until the next probe, so a held scan still sees it
        hit_next = hit_reg;
        if (cmd.probe_pos || cmd.probe_val)
        begin
            hit_next = (cmd.probe_pos && at_idx && live) ||
                       (cmd.probe_val && live && (data_reg == key));
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

>>> sv/sequential_list_engine.sv
// ============================================================================
// sequential_list_engine: ordered list of signed 32-bit words
// Insert, delete, get, locate and clear on a list held in a chain of cells.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one word carries action, position
//   and value. A word is taken at a rising edge with in_valid high and
//   in_stall low. in_stall is high while an operation is in progress.
//   Output channel (out_valid / out_stall): one result word per input word
//   with status, read_value, found_position, count and is_empty.
// Operation sequence:
//   Once the input word is taken, an execute cycle in which every cell
//   shifts or compares in parallel is followed by a scan cycle that picks
//   the first flagged cell and loads the output register; the scan holds
//   while the output register is full. A new word can be taken the cycle
//   after the scan, so words are not overlapped.
// Reset:
//   rst_n clears the count (empty list), the FSM and the output valid.
//   Entries are not cleared; a slot is only read after it was written.
// Stall:
//   The result waits in the output register while out_stall is high. The
//   next input word is still taken and executed; its scan holds until the
//   output register frees up.
// ============================================================================
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sle_pkg::ACTION_W-1:0]          action,
    input  logic [sle_pkg::POS_W-1:0]             position,
    input  logic signed [sle_pkg::VALUE_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sle_pkg::STATUS_W-1:0]          status,
    output logic signed [sle_pkg::VALUE_W-1:0]    read_value,
    output logic [sle_pkg::COUNT_OUT_W-1:0]       found_position,
    output logic [sle_pkg::COUNT_OUT_W-1:0]       count,
    output logic                                  is_empty
);
    import sle_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // FSM and captured input word
    state_t              state_reg;
    state_t              state_next;
    logic [ACTION_W-1:0] act_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [VALUE_W-1:0]  val_reg;

    // list state and per-operation bookkeeping
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    status_t             op_status_reg;
    status_t             op_status_next;
    logic                get_reg;
    logic                get_next;
    logic                loc_reg;
    logic                loc_next;

    // output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                status_out_reg;
    logic [VALUE_W-1:0]     read_value_reg;
    logic [COUNT_OUT_W-1:0] found_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                   empty_reg;

    // cell chain
    cell_cmd_t           cmd;
    logic [IDX_W-1:0]    idx;
    logic [VALUE_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]    cell_hit;

    // scan
    logic [DEPTH-1:0]    first_hit;
    logic                any_hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [VALUE_W-1:0]  hit_data;
    logic [CNT_W-1:0]    hit_pos;
    logic                accept_in;
    logic                load_out;

    // position checks
    logic [CMP_W-1:0]    pos_cmp;
    logic [CMP_W-1:0]    cnt_cmp;
    logic [CMP_W-1:0]    depth_cmp;
    logic [CMP_W-1:0]    pos_m1;
    logic                pos_in_list;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign load_out  = (state_reg == S_SCAN) && (!out_valid_reg || !out_stall);

    assign pos_cmp     = CMP_W'(pos_reg);
    assign cnt_cmp     = CMP_W'(count_reg);
    assign depth_cmp   = CMP_W'(DEPTH);
    assign pos_m1      = pos_cmp - CMP_W'(1);
    assign pos_in_list = (pos_cmp != '0) && (pos_cmp <= cnt_cmp);

    // ------------------------------------------------------------------
    // FSM: idle -> execute -> scan, hold in scan while the output is full
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Action decode in the execute cycle: range checks, new count and
    // the command word broadcast to the cells
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd            = '0;
        idx            = '0;
        count_next     = count_reg;
        op_status_next = op_status_reg;
        get_next       = get_reg;
        loc_next       = loc_reg;
        if (state_reg == S_EXEC)
        begin
            op_status_next = ST_OK;
            get_next       = 1'b0;
            loc_next       = 1'b0;
            unique case (act_reg)
                ACT_INSERT:
                begin
                    // full check comes before the range check
                    if (cnt_cmp == depth_cmp)
                    begin
                        op_status_next = ST_FULL;
                    end
                    else if ((pos_cmp == '0) || (pos_cmp > depth_cmp))
                    begin
                        op_status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        // a position past the end appends
                        idx        = (pos_cmp > cnt_cmp) ? cnt_cmp[IDX_W-1:0]
                                                         : pos_m1[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_DELETE:
                begin
                    if (!pos_in_list)
                    begin
                        op_status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.remove = 1'b1;
                        idx        = pos_m1[IDX_W-1:0];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                ACT_GET:
                begin
                    if (!pos_in_list)
                    begin
                        op_status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.probe_pos = 1'b1;
                        idx           = pos_m1[IDX_W-1:0];
                        get_next      = 1'b1;
                    end
                end
                ACT_LOCATE:
                begin
                    cmd.probe_val = 1'b1;
                    loc_next      = 1'b1;
                end
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // spare codes: report the count, change nothing
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell k takes from k-1 on insert, from k+1 on delete
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [VALUE_W-1:0] left_d;
        logic [VALUE_W-1:0] right_d;

        if (k == 0)
        begin : g_first
            assign left_d = val_reg;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[k];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[k+1];
        end

        sle_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (k)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (idx),
            .count      (count_reg),
            .key        (val_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[k]),
            .hit        (cell_hit[k])
        );
    end

    // ------------------------------------------------------------------
    // Scan: isolate the lowest flagged cell, encode its index, pick data
    // ------------------------------------------------------------------
    assign first_hit = cell_hit & (~cell_hit + DEPTH'(1));
    assign any_hit   = |cell_hit;

    always_comb
    begin
        hit_idx  = '0;
        hit_data = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (first_hit[k])
            begin
                hit_idx  = hit_idx | IDX_W'(k);
                hit_data = hit_data | cell_data[k];
            end
        end
    end

    assign hit_pos = CNT_W'(hit_idx) + CNT_W'(1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            act_reg <= action;
            pos_reg <= position;
            val_reg <= value;
        end
        op_status_reg <= op_status_next;
        get_reg       <= get_next;
        loc_reg       <= loc_next;
        if (load_out)
        begin
            if (loc_reg)
            begin
                status_out_reg <= any_hit ? ST_OK : ST_MISS;
            end
            else
            begin
                status_out_reg <= op_status_reg;
            end
            read_value_reg <= get_reg ? hit_data : '0;
            found_reg      <= (loc_reg && any_hit) ? COUNT_OUT_W'(hit_pos) : '0;
            count_out_reg  <= COUNT_OUT_W'(count_reg);
            empty_reg      <= (count_reg == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_reg;
    assign count          = count_out_reg;
    assign is_empty       = empty_reg;

`ifndef SYNTHESIS
    // the count never passes the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count exceeds depth");

    // a taken input word always enters the execute cycle next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == S_EXEC))
        else $error("accepted word did not execute");

    // a new result only appears from the scan cycle
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_SCAN))
        else $error("result presented outside scan");

    // a full refusal reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_out_reg == ST_FULL)) |->
            (count_out_reg == COUNT_OUT_W'(DEPTH)))
        else $error("full status with list not full");
`endif

endmodule
